>>> sv/vpma_pkg.sv
`default_nettype none
package vpma_pkg;

   localparam int PLANE_BYTES = 65536;
   localparam int PLANE_COUNT = 4;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = PLANE_COUNT * BYTE_W;
   localparam int ADDR_W      = 20;
   localparam int OFFSET_W    = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [ADDR_W-1:0]   HIGH_WINDOW = 20'hB0000;
   localparam logic [OFFSET_W-1:0] LOW_MASK    = 16'hFFFF;
   localparam logic [OFFSET_W-1:0] HIGH_MASK   = 16'h7FFF;
   localparam logic [PLANE_COUNT-1:0] EVEN_PLANES = 4'h5;
   localparam logic [PLANE_COUNT-1:0] ODD_PLANES  = 4'hA;
   localparam logic [PLANE_COUNT-1:0] ALL_PLANES  = 4'hF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE_FLAGS      = 3'd0,
      CSR_MAP_MASK        = 3'd1,
      CSR_SET_RESET_PAIR  = 3'd2,
      CSR_DATA_ROTATE     = 3'd3,
      CSR_READ_MAP_SELECT = 3'd4,
      CSR_GRAPHICS_MODE   = 3'd5,
      CSR_COLOR_COMPARE   = 3'd6,
      CSR_BIT_MASK        = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      WMODE_SET_RESET = 2'd0,
      WMODE_LATCH     = 2'd1,
      WMODE_COLOR     = 2'd2,
      WMODE_AND_MASK  = 2'd3
   } write_mode_type;

   typedef enum logic [1:0] {
      FN_NONE = 2'd0,
      FN_AND  = 2'd1,
      FN_OR   = 2'd2,
      FN_XOR  = 2'd3
   } logic_fn_type;

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_NODEC,
      KIND_CGA_READ,
      KIND_PLANE_READ,
      KIND_COMPARE
   } rsp_kind_type;

   typedef struct packed {
      logic [1:0] mode_flags;
      logic [3:0] map_mask;
      logic [7:0] set_reset_pair;
      logic [4:0] data_rotate;
      logic [1:0] read_map_select;
      logic [7:0] graphics_mode;
      logic [7:0] color_compare_pair;
      logic [7:0] bit_mask;
   } cfg_type;

   typedef struct packed {
      rsp_kind_type kind;
      logic [1:0]   plane_sel;
   } stage_ctrl_type;

endpackage
`default_nettype wire

>>> sv/vpma_if.sv
`default_nettype none
interface vpma_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [vpma_pkg::ADDR_W-1:0] address;
   logic [vpma_pkg::BYTE_W-1:0] write_data;

   modport source (output valid, operation, address, write_data, input ready);
   modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface vpma_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vpma_pkg::BYTE_W-1:0] read_data;
   logic                        not_decoded;

   modport source (output valid, read_data, not_decoded, input ready);
   modport sink   (input valid, read_data, not_decoded, output ready);
endinterface
`default_nettype wire

>>> sv/vpma_csr.sv
`default_nettype none
module vpma_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [vpma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [vpma_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output vpma_pkg::cfg_type                      cfg
);

   vpma_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (vpma_pkg::csr_index_type'(csr_index))
            vpma_pkg::CSR_MODE_FLAGS:      cfg_ff.mode_flags         <= csr_wdata[1:0];
            vpma_pkg::CSR_MAP_MASK:        cfg_ff.map_mask           <= csr_wdata[3:0];
            vpma_pkg::CSR_SET_RESET_PAIR:  cfg_ff.set_reset_pair     <= csr_wdata;
            vpma_pkg::CSR_DATA_ROTATE:     cfg_ff.data_rotate        <= csr_wdata[4:0];
            vpma_pkg::CSR_READ_MAP_SELECT: cfg_ff.read_map_select    <= csr_wdata[1:0];
            vpma_pkg::CSR_GRAPHICS_MODE:   cfg_ff.graphics_mode      <= csr_wdata;
            vpma_pkg::CSR_COLOR_COMPARE:   cfg_ff.color_compare_pair <= csr_wdata;
            vpma_pkg::CSR_BIT_MASK:        cfg_ff.bit_mask           <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> sv/vpma_mem.sv
`default_nettype none
module vpma_mem #(
   parameter int DEPTH = vpma_pkg::PLANE_BYTES,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [vpma_pkg::PLANE_COUNT-1:0]  wr_be,
   input  wire logic [vpma_pkg::WORD_W-1:0]       wr_data,
   input  wire logic                              rd_en,
   input  wire logic [IDX_W-1:0]                  addr,
   output logic      [vpma_pkg::WORD_W-1:0]       rd_data
);

   logic [vpma_pkg::WORD_W-1:0] mem [DEPTH];
   logic [vpma_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int k = 0; k < vpma_pkg::PLANE_COUNT; k++) begin
            if (wr_be[k]) begin
               mem[addr][k*vpma_pkg::BYTE_W +: vpma_pkg::BYTE_W] <=
                  wr_data[k*vpma_pkg::BYTE_W +: vpma_pkg::BYTE_W];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/vpma_issue.sv
`default_nettype none
module vpma_issue #(
   parameter int PLANE_BYTES = vpma_pkg::PLANE_BYTES,
   localparam int IDX_W = $clog2(PLANE_BYTES)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic                              in_operation,
   input  wire logic [vpma_pkg::ADDR_W-1:0]       in_address,
   input  wire logic [vpma_pkg::BYTE_W-1:0]       in_write_data,
   input  wire vpma_pkg::cfg_type                 cfg,
   input  wire logic [vpma_pkg::WORD_W-1:0]       latches,
   input  wire logic                              next_open,
   output logic                                   issue_valid,
   output vpma_pkg::stage_ctrl_type               issue_ctrl,
   output logic                                   mem_wr_en,
   output logic [vpma_pkg::PLANE_COUNT-1:0]       mem_wr_be,
   output logic [vpma_pkg::WORD_W-1:0]            mem_wr_data,
   output logic                                   mem_rd_en,
   output logic [IDX_W-1:0]                       mem_addr
);

   logic                          s1_valid_ff;
   logic                          s1_op_ff;
   logic [vpma_pkg::ADDR_W-1:0]   s1_addr_ff;
   logic [vpma_pkg::BYTE_W-1:0]   s1_data_ff;

   logic                          s1_open;
   logic                          advance;
   logic [vpma_pkg::OFFSET_W-1:0] host_off;
   logic [vpma_pkg::OFFSET_W-1:0] plane_off;
   logic                          cga_map;
   logic                          mem_enabled;
   logic                          odd_even;
   logic [vpma_pkg::PLANE_COUNT-1:0] plane_mask;
   logic [vpma_pkg::WORD_W-1:0]   lane_data;

   // Write-path byte lane: write mode, then in modes 0/2 logic function, bit mask.
   function automatic logic [vpma_pkg::BYTE_W-1:0] write_lane(
      input vpma_pkg::cfg_type         c,
      input logic [1:0]                lane,
      input logic [vpma_pkg::BYTE_W-1:0] data,
      input logic [vpma_pkg::BYTE_W-1:0] lt
   );
      logic [vpma_pkg::BYTE_W-1:0]   bt;
      logic [2*vpma_pkg::BYTE_W-1:0] dbl;
      bt  = '0;
      dbl = '0;
      unique case (vpma_pkg::write_mode_type'(c.graphics_mode[1:0]))
         vpma_pkg::WMODE_SET_RESET: begin
            bt  = c.set_reset_pair[{1'b1, lane}] ? {8{c.set_reset_pair[{1'b0, lane}]}}
                                                 : data;
            dbl = {bt, bt} >> c.data_rotate[2:0];
            bt  = dbl[vpma_pkg::BYTE_W-1:0];
         end
         vpma_pkg::WMODE_LATCH:    bt = lt;
         vpma_pkg::WMODE_COLOR:    bt = {8{data[{1'b0, lane}]}};
         vpma_pkg::WMODE_AND_MASK: bt = {4'b0, c.set_reset_pair[3:0]} & c.bit_mask;
         default:                  bt = lt;
      endcase
      if (!c.graphics_mode[0]) begin
         case (vpma_pkg::logic_fn_type'(c.data_rotate[4:3]))
            vpma_pkg::FN_AND: bt = bt & lt;
            vpma_pkg::FN_OR:  bt = bt | lt;
            vpma_pkg::FN_XOR: bt = bt ^ lt;
            default:          bt = bt;
         endcase
         bt = (bt & c.bit_mask) | (lt & ~c.bit_mask);
      end
      return bt;
   endfunction

   assign s1_open  = !s1_valid_ff || next_open;
   assign in_ready = s1_open;
   assign advance  = s1_valid_ff && next_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open && in_valid) begin
         s1_op_ff   <= in_operation;
         s1_addr_ff <= in_address;
         s1_data_ff <= in_write_data;
      end
   end

   assign cga_map     = cfg.mode_flags[1];
   assign mem_enabled = cfg.mode_flags[0];
   assign odd_even    = cfg.graphics_mode[4];

   always_comb begin
      host_off = (s1_addr_ff < vpma_pkg::HIGH_WINDOW)
               ? (s1_addr_ff[vpma_pkg::OFFSET_W-1:0] & vpma_pkg::LOW_MASK)
               : (s1_addr_ff[vpma_pkg::OFFSET_W-1:0] & vpma_pkg::HIGH_MASK);
      plane_off = (cga_map || odd_even) ? {1'b0, host_off[vpma_pkg::OFFSET_W-1:1]} : host_off;
      // One subtract wraps the offset when it is below twice the plane size.
      if ({1'b0, plane_off} >= (vpma_pkg::OFFSET_W+1)'(PLANE_BYTES)) begin
         mem_addr = IDX_W'({1'b0, plane_off} - (vpma_pkg::OFFSET_W+1)'(PLANE_BYTES));
      end else begin
         mem_addr = IDX_W'(plane_off);
      end
   end

   always_comb begin
      for (int k = 0; k < vpma_pkg::PLANE_COUNT; k++) begin
         lane_data[k*vpma_pkg::BYTE_W +: vpma_pkg::BYTE_W] =
            write_lane(cfg, 2'(k), s1_data_ff, latches[k*vpma_pkg::BYTE_W +: vpma_pkg::BYTE_W]);
      end
   end

   always_comb begin
      if (odd_even) begin
         plane_mask = cfg.map_mask & (host_off[0] ? vpma_pkg::ODD_PLANES : vpma_pkg::EVEN_PLANES);
      end else begin
         plane_mask = cfg.map_mask & vpma_pkg::ALL_PLANES;
      end
      mem_wr_en = advance && s1_op_ff && (cga_map || mem_enabled);
      mem_rd_en = advance && !s1_op_ff && (cga_map || mem_enabled);
      if (cga_map) begin
         mem_wr_be   = host_off[0] ? 4'b0010 : 4'b0001;
         mem_wr_data = {vpma_pkg::PLANE_COUNT{s1_data_ff}};
      end else begin
         mem_wr_be   = plane_mask;
         mem_wr_data = lane_data;
      end
   end

   always_comb begin
      issue_valid          = advance;
      issue_ctrl.plane_sel = {1'b0, host_off[0]};
      if (cga_map) begin
         issue_ctrl.kind = s1_op_ff ? vpma_pkg::KIND_ZERO : vpma_pkg::KIND_CGA_READ;
      end else if (!mem_enabled) begin
         issue_ctrl.kind = vpma_pkg::KIND_NODEC;
      end else if (s1_op_ff) begin
         issue_ctrl.kind = vpma_pkg::KIND_ZERO;
      end else begin
         issue_ctrl.kind = cfg.graphics_mode[3] ? vpma_pkg::KIND_COMPARE
                                                : vpma_pkg::KIND_PLANE_READ;
         issue_ctrl.plane_sel = odd_even ? {cfg.read_map_select[1], host_off[0]}
                                         : cfg.read_map_select;
      end
   end

endmodule
`default_nettype wire

>>> sv/vpma_result.sv
`default_nettype none
module vpma_result (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire vpma_pkg::cfg_type                 cfg,
   input  wire logic                              issue_valid,
   input  wire vpma_pkg::stage_ctrl_type          issue_ctrl,
   input  wire logic [vpma_pkg::WORD_W-1:0]       mem_rd_data,
   output logic                                   stage_open,
   output logic [vpma_pkg::WORD_W-1:0]            latches,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [vpma_pkg::BYTE_W-1:0]            rsp_read_data,
   output logic                                   rsp_not_decoded
);

   logic                        s2_valid_ff;
   vpma_pkg::stage_ctrl_type    s2_ctrl_ff;
   logic [vpma_pkg::WORD_W-1:0] latches_ff;
   logic                        rsp_valid_ff;
   logic [vpma_pkg::BYTE_W-1:0] rsp_data_ff;
   logic                        rsp_nd_ff;

   logic                        out_open;
   logic                        load_latches;
   logic [vpma_pkg::BYTE_W-1:0] rd_in;
   logic                        nd_in;
   logic [vpma_pkg::PLANE_COUNT-1:0] color;

   assign out_open   = !rsp_valid_ff || rsp_ready;
   assign stage_open = !s2_valid_ff || out_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (stage_open) begin
         s2_valid_ff <= issue_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_open && issue_valid) begin
         s2_ctrl_ff <= issue_ctrl;
      end
   end

   assign load_latches = s2_valid_ff &&
                         (s2_ctrl_ff.kind == vpma_pkg::KIND_PLANE_READ ||
                          s2_ctrl_ff.kind == vpma_pkg::KIND_COMPARE);

   // A write issued in the same cycle as a read leaves this stage sees the new latches.
   assign latches = load_latches ? mem_rd_data : latches_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         latches_ff <= '0;
      end else if (load_latches && out_open) begin
         latches_ff <= mem_rd_data;
      end
   end

   always_comb begin
      color = '0;
      rd_in = '0;
      nd_in = 1'b0;
      case (s2_ctrl_ff.kind)
         vpma_pkg::KIND_NODEC: nd_in = 1'b1;
         vpma_pkg::KIND_CGA_READ, vpma_pkg::KIND_PLANE_READ: begin
            rd_in = mem_rd_data[{s2_ctrl_ff.plane_sel, 3'b000} +: vpma_pkg::BYTE_W];
         end
         vpma_pkg::KIND_COMPARE: begin
            for (int b = 0; b < vpma_pkg::BYTE_W; b++) begin
               for (int k = 0; k < vpma_pkg::PLANE_COUNT; k++) begin
                  color[k] = mem_rd_data[k*vpma_pkg::BYTE_W + b];
               end
               rd_in[b] = ~|((cfg.color_compare_pair[3:0] ^ color) &
                             cfg.color_compare_pair[7:4]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open && s2_valid_ff) begin
         rsp_data_ff <= rd_in;
         rsp_nd_ff   <= nd_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_not_decoded = rsp_nd_ff;

endmodule
`default_nettype wire

>>> sv/vga_planar_memory_access_core.sv
// Host-side memory datapath of a planar graphics controller.
// Host accesses arrive as beats on req_chan (operation, address, write_data);
// every access returns exactly one beat on rsp_chan (read_data, not_decoded),
// in order. Writes return zero data. Registers are to be written through the csr_
// port only while no access is in flight; the block itself does not enforce it.
// Throughput is one access per cycle while rsp_chan takes every beat. After a
// request beat is accepted it passes the input register, where the address is
// decoded and the plane word is written or read, and then the result stage,
// which takes the registered plane word, loads the latches and forms the read
// byte or color-compare result for the response register.
// When rsp_chan stalls, the response register holds its beat and the empty
// stages ahead of it still fill, so up to three accesses are held before
// req_chan.ready drops.
// Reset clears the registers, the read latches and the pipeline. The plane
// memory is not cleared; a location must be written before it is read.
`default_nettype none
module vga_planar_memory_access_core #(
   parameter int PLANE_BYTES = vpma_pkg::PLANE_BYTES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   vpma_req_if.sink                               req_chan,
   vpma_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [vpma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [vpma_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(PLANE_BYTES);

   vpma_pkg::cfg_type                cfg;
   vpma_pkg::stage_ctrl_type         issue_ctrl;
   logic                             issue_valid;
   logic                             stage_open;
   logic [vpma_pkg::WORD_W-1:0]      latches;
   logic                             mem_wr_en;
   logic [vpma_pkg::PLANE_COUNT-1:0] mem_wr_be;
   logic [vpma_pkg::WORD_W-1:0]      mem_wr_data;
   logic                             mem_rd_en;
   logic [IDX_W-1:0]                 mem_addr;
   logic [vpma_pkg::WORD_W-1:0]      mem_rd_data;

   vpma_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vpma_issue #(
      .PLANE_BYTES (PLANE_BYTES)
   ) u_issue (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .in_operation  (req_chan.operation),
      .in_address    (req_chan.address),
      .in_write_data (req_chan.write_data),
      .cfg           (cfg),
      .latches       (latches),
      .next_open     (stage_open),
      .issue_valid   (issue_valid),
      .issue_ctrl    (issue_ctrl),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_be     (mem_wr_be),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_addr      (mem_addr)
   );

   vpma_mem #(
      .DEPTH (PLANE_BYTES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_be   (mem_wr_be),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .rd_data (mem_rd_data)
   );

   vpma_result u_result (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .issue_valid     (issue_valid),
      .issue_ctrl      (issue_ctrl),
      .mem_rd_data     (mem_rd_data),
      .stage_open      (stage_open),
      .latches         (latches),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_read_data   (rsp_chan.read_data),
      .rsp_not_decoded (rsp_chan.not_decoded)
   );

endmodule
`default_nettype wire

>>> bench/vga_planar_memory_access_checker.sv
`timescale 1ns / 100ps

module vga_planar_memory_access_checker
   import vpma_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   vpma_req_if                        req_mon,
   vpma_rsp_if                        rsp_mon,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         pending,
   output int                         mismatches
);

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              not_decoded;
   } response_type;

   cfg_type           regs;
   logic [BYTE_W-1:0] latch_bytes [PLANE_COUNT];
   logic [WORD_W-1:0] plane_words [int unsigned];
   response_type      expected_responses [$];

   function automatic logic [WORD_W-1:0] stored_word(input int unsigned idx);
      return plane_words.exists(idx) ? plane_words[idx] : '0;
   endfunction

   // Works out the response to one host access and updates the planes and latches.
   task automatic predict_access(input logic write_op, input logic [ADDR_W-1:0] addr,
                                 input logic [BYTE_W-1:0] wdata);
      logic [OFFSET_W-1:0]    off;
      logic [PLANE_COUNT-1:0] planes;
      logic [PLANE_COUNT-1:0] col;
      logic [1:0]             sel;
      logic [BYTE_W-1:0]      bt;
      logic [BYTE_W-1:0]      lt;
      logic [15:0]            twin;
      logic [WORD_W-1:0]      word;
      write_mode_type         wmode;
      logic_fn_type           fn;
      response_type           r;
      int unsigned            idx;
      int                     k;
      int                     b;
      r = '0;
      off = (addr < HIGH_WINDOW) ? (addr[15:0] & LOW_MASK) : (addr[15:0] & HIGH_MASK);
      wmode = write_mode_type'(regs.graphics_mode[1:0]);
      fn = logic_fn_type'(regs.data_rotate[4:3]);
      if (regs.mode_flags[1]) begin
         // Byte-interleaved mapping: even bytes in plane 0, odd bytes in plane 1.
         idx = off >> 1;
         word = stored_word(idx);
         if (write_op) begin
            word[8*off[0] +: 8] = wdata;
            plane_words[idx] = word;
         end else begin
            r.read_data = word[8*off[0] +: 8];
         end
      end else if (!regs.mode_flags[0]) begin
         r.not_decoded = 1'b1;
      end else if (write_op) begin
         planes = regs.map_mask;
         if (regs.graphics_mode[4]) begin
            planes = planes & (off[0] ? ODD_PLANES : EVEN_PLANES);
            off = off >> 1;
         end
         idx = off;
         word = stored_word(idx);
         for (k = 0; k < PLANE_COUNT; k++) begin
            if (planes[k]) begin
               lt = latch_bytes[k];
               case (wmode)
                  WMODE_SET_RESET: begin
                     bt = regs.set_reset_pair[4+k] ? {8{regs.set_reset_pair[k]}} : wdata;
                     twin = {bt, bt} >> regs.data_rotate[2:0];
                     bt = twin[7:0];
                  end
                  WMODE_LATCH: bt = lt;
                  WMODE_COLOR: bt = {8{wdata[k]}};
                  WMODE_AND_MASK: bt = {4'h0, regs.set_reset_pair[3:0]} & regs.bit_mask;
               endcase
               if (wmode == WMODE_SET_RESET || wmode == WMODE_COLOR) begin
                  case (fn)
                     FN_AND: bt = bt & lt;
                     FN_OR: bt = bt | lt;
                     FN_XOR: bt = bt ^ lt;
                     default: ;
                  endcase
                  bt = (bt & regs.bit_mask) | (lt & ~regs.bit_mask);
               end
               word[8*k +: 8] = bt;
            end
         end
         plane_words[idx] = word;
      end else begin
         sel = regs.read_map_select;
         if (regs.graphics_mode[4]) begin
            sel = {regs.read_map_select[1], off[0]};
            off = off >> 1;
         end
         word = stored_word(off);
         for (k = 0; k < PLANE_COUNT; k++) latch_bytes[k] = word[8*k +: 8];
         if (regs.graphics_mode[3]) begin
            for (b = 0; b < BYTE_W; b++) begin
               for (k = 0; k < PLANE_COUNT; k++) col[k] = latch_bytes[k][b];
               if (((regs.color_compare_pair[3:0] ^ col) & regs.color_compare_pair[7:4]) == 0)
                  r.read_data[b] = 1'b1;
            end
         end else begin
            r.read_data = latch_bytes[sel];
         end
      end
      expected_responses.push_back(r);
   endtask

   always @(posedge clock) begin
      response_type r;
      int k;
      if (reset) begin
         regs = '0;
         for (k = 0; k < PLANE_COUNT; k++) latch_bytes[k] = '0;
         expected_responses.delete();
         mismatches = 0;
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_MODE_FLAGS: regs.mode_flags = csr_wdata[1:0];
               CSR_MAP_MASK: regs.map_mask = csr_wdata[3:0];
               CSR_SET_RESET_PAIR: regs.set_reset_pair = csr_wdata;
               CSR_DATA_ROTATE: regs.data_rotate = csr_wdata[4:0];
               CSR_READ_MAP_SELECT: regs.read_map_select = csr_wdata[1:0];
               CSR_GRAPHICS_MODE: regs.graphics_mode = csr_wdata;
               CSR_COLOR_COMPARE: regs.color_compare_pair = csr_wdata;
               CSR_BIT_MASK: regs.bit_mask = csr_wdata;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predict_access(req_mon.operation, req_mon.address, req_mon.write_data);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response beat with no access outstanding");
               mismatches++;
            end else begin
               r = expected_responses.pop_front();
               if (rsp_mon.read_data !== r.read_data) begin
                  $error("read_data: expected %02h, got %02h", r.read_data, rsp_mon.read_data);
                  mismatches++;
               end
               if (rsp_mon.not_decoded !== r.not_decoded) begin
                  $error("not_decoded: expected %0b, got %0b", r.not_decoded,
                         rsp_mon.not_decoded);
                  mismatches++;
               end
            end
         end
         pending <= expected_responses.size();
      end
   end

endmodule

>>> bench/vga_planar_memory_access_core_test.sv
`timescale 1ns / 100ps

module vga_planar_memory_access_core_test;
   import vpma_pkg::*;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
   localparam int   WATCHDOG_LIMIT = 1000;
   localparam int   RANDOM_PHASES  = 30;
   localparam int   PHASE_ITEMS    = 65;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    pending;
   int                    mismatches;
   int                    idle_cycles;
   bit                    steady;

   cfg_type                shadow;
   logic [PLANE_COUNT-1:0] filled_planes [int unsigned];
   logic [OFFSET_W-1:0]    hot_offsets [16];
   logic [OFFSET_W-1:0]    low_part;
   logic [ADDR_W-1:0]      rand_addr;
   logic [BYTE_W-1:0]      rand_data;
   int                     phase;
   int                     n;
   int                     pick;

   vpma_req_if req_chan ();
   vpma_rsp_if rsp_chan ();

   vga_planar_memory_access_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vga_planar_memory_access_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .mismatches (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Waits for the pipeline to drain, then rewrites every register.
   task automatic settle(input logic [1:0] mf, input logic [3:0] mm, input logic [7:0] srp,
                         input logic [4:0] dr, input logic [1:0] rms, input logic [7:0] gm,
                         input logic [7:0] ccp, input logic [7:0] bm);
      cfg_type           c;
      logic [BYTE_W-1:0] v;
      int                i;
      c.mode_flags = mf;
      c.map_mask = mm;
      c.set_reset_pair = srp;
      c.data_rotate = dr;
      c.read_map_select = rms;
      c.graphics_mode = gm;
      c.color_compare_pair = ccp;
      c.bit_mask = bm;
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      for (i = 0; i < 8; i++) begin
         case (csr_index_type'(i))
            CSR_MODE_FLAGS: v = {6'b0, c.mode_flags};
            CSR_MAP_MASK: v = {4'b0, c.map_mask};
            CSR_SET_RESET_PAIR: v = c.set_reset_pair;
            CSR_DATA_ROTATE: v = {3'b0, c.data_rotate};
            CSR_READ_MAP_SELECT: v = {6'b0, c.read_map_select};
            CSR_GRAPHICS_MODE: v = c.graphics_mode;
            CSR_COLOR_COMPARE: v = c.color_compare_pair;
            default: v = c.bit_mask;
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= v;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      shadow = c;
   endtask

   // Sends one access; unless mode_flags is 0, reads of part-filled words become writes.
   task automatic host_access(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] data);
      logic [OFFSET_W-1:0]    off;
      logic [PLANE_COUNT-1:0] planes;
      logic                   is_wr;
      int unsigned            idx;
      int                     gap;
      is_wr = (op == OP_WRITE);
      off = (addr < HIGH_WINDOW) ? addr[15:0] : (addr[15:0] & HIGH_MASK);
      idx = (shadow.mode_flags[1] || shadow.graphics_mode[4]) ? (off >> 1) : off;
      if (!is_wr && shadow.mode_flags != 2'b00 &&
          !(filled_planes.exists(idx) && filled_planes[idx] == ALL_PLANES))
         is_wr = 1'b1;
      if (is_wr) begin
         if (shadow.mode_flags[1])
            planes = off[0] ? 4'b0010 : 4'b0001;
         else if (shadow.mode_flags[0])
            planes = shadow.map_mask &
                     (shadow.graphics_mode[4] ? (off[0] ? ODD_PLANES : EVEN_PLANES)
                                              : ALL_PLANES);
         else
            planes = '0;
         if (planes != 0)
            filled_planes[idx] = (filled_planes.exists(idx) ? filled_planes[idx] : '0) | planes;
      end
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= is_wr ? OP_WRITE : OP_READ;
      req_chan.address <= addr;
      req_chan.write_data <= data;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   task automatic random_settings();
      logic [1:0] mf;
      logic [3:0] mm;
      logic [7:0] bm;
      pick = $urandom_range(0, 9);
      mf = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd2 : (pick == 2) ? 2'd3 : 2'd1;
      mm = ($urandom_range(0, 2) == 0) ? ALL_PLANES : 4'($urandom_range(0, 15));
      bm = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      settle(mf, mm, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
             2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), bm);
   endtask

   // Response side: a random stall before each beat, none in steady phases.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.operation <= OP_READ;
      req_chan.address <= '0;
      req_chan.write_data <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_MODE_FLAGS;
      csr_wdata <= '0;
      reset <= 1'b1;
      steady = 1'b0;
      shadow = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      hot_offsets[0] = 16'h0000;
      hot_offsets[1] = 16'hFFFF;
      hot_offsets[2] = 16'h7FFF;
      hot_offsets[3] = 16'h8000;
      hot_offsets[4] = 16'h5555;
      hot_offsets[5] = 16'hAAAA;
      hot_offsets[6] = 16'h0001;
      hot_offsets[7] = 16'hFFFE;
      for (n = 8; n < 16; n++) hot_offsets[n] = 16'($urandom_range(0, 16'hFFFF));

      // Fill every plane of each word that the hot offsets can reach in any mapping.
      settle(2'd1, ALL_PLANES, 8'h00, 5'd0, 2'd0, 8'h00, 8'h00, 8'hFF);
      for (n = 0; n < 16; n++) begin
         host_access(OP_WRITE, {4'h0, hot_offsets[n]}, 8'($urandom_range(0, 255)));
         host_access(OP_WRITE, {4'h0, hot_offsets[n] & HIGH_MASK}, 8'($urandom_range(0, 255)));
         host_access(OP_WRITE, {4'h0, hot_offsets[n] >> 1}, 8'($urandom_range(0, 255)));
         host_access(OP_WRITE, {4'h0, (hot_offsets[n] & HIGH_MASK) >> 1},
                     8'($urandom_range(0, 255)));
      end

      // Memory disabled: both accesses are ignored.
      settle(2'd0, ALL_PLANES, 8'h00, 5'd0, 2'd0, 8'h00, 8'h00, 8'hFF);
      host_access(OP_WRITE, 20'h12345, 8'h5A);
      host_access(OP_READ, 20'hFFFFF, 8'h00);
      // Byte-interleaved mapping, alone and with access enabled, across the window edge.
      settle(2'd2, 4'h0, 8'h00, 5'd0, 2'd0, 8'h00, 8'h00, 8'h00);
      host_access(OP_WRITE, 20'hB0000, 8'hC3);
      host_access(OP_READ, 20'hB0000, 8'h00);
      host_access(OP_READ, 20'hAFFFF, 8'h00);
      settle(2'd3, 4'h0, 8'h00, 5'd0, 2'd0, 8'h00, 8'h00, 8'h00);
      host_access(OP_WRITE, 20'hAFFFF, 8'h3C);
      host_access(OP_READ, 20'hAFFFF, 8'h00);
      // Set/reset with rotate, XOR and a partial bit mask.
      settle(2'd1, ALL_PLANES, 8'h5A, {FN_XOR, 3'd3}, 2'd0, {6'b0, WMODE_SET_RESET},
             8'h00, 8'hF0);
      host_access(OP_READ, 20'h00000, 8'h00);
      host_access(OP_WRITE, 20'h00000, 8'h81);
      host_access(OP_READ, 20'h00000, 8'h00);
      // Latch copy ignores the logic function and the bit mask.
      settle(2'd1, ALL_PLANES, 8'h00, {FN_AND, 3'd0}, 2'd1, {6'b0, WMODE_LATCH}, 8'h00, 8'h00);
      host_access(OP_READ, 20'h0FFFF, 8'h00);
      host_access(OP_WRITE, 20'h07FFF, 8'h00);
      host_access(OP_READ, 20'h07FFF, 8'h00);
      // Color expansion with OR and a full rotate count.
      settle(2'd1, ALL_PLANES, 8'h00, {FN_OR, 3'd7}, 2'd2, {6'b0, WMODE_COLOR}, 8'h00, 8'h3C);
      host_access(OP_READ, 20'h08000, 8'h00);
      host_access(OP_WRITE, 20'h08000, 8'h0A);
      host_access(OP_READ, 20'h08000, 8'h00);
      settle(2'd1, ALL_PLANES, 8'h07, 5'd0, 2'd3, {6'b0, WMODE_AND_MASK}, 8'h00, 8'hAA);
      host_access(OP_WRITE, 20'h05555, 8'hFF);
      host_access(OP_READ, 20'h05555, 8'h00);
      // Odd/even addressing with color compare reads, then with plain reads.
      settle(2'd1, ALL_PLANES, 8'h00, 5'd0, 2'd3, 8'h18, 8'hF5, 8'hFF);
      host_access(OP_WRITE, 20'h00001, 8'hA5);
      host_access(OP_WRITE, 20'h00000, 8'h5A);
      host_access(OP_READ, 20'h00001, 8'h00);
      host_access(OP_READ, 20'h00000, 8'h00);
      settle(2'd1, 4'h9, 8'h00, 5'd0, 2'd2, 8'h10, 8'h00, 8'hFF);
      host_access(OP_WRITE, 20'h00003, 8'h77);
      host_access(OP_READ, 20'h00003, 8'h00);
      host_access(OP_READ, 20'h00002, 8'h00);
      // Every register at its maximum, then with odd/even off and mode flags 1.
      settle(2'd3, ALL_PLANES, 8'hFF, 5'h1F, 2'd3, 8'hFF, 8'hFF, 8'hFF);
      host_access(OP_WRITE, 20'hFFFFF, 8'hFF);
      host_access(OP_READ, 20'hFFFFF, 8'h00);
      settle(2'd1, ALL_PLANES, 8'hFF, 5'h1F, 2'd3, 8'hEF, 8'hFF, 8'hFF);
      host_access(OP_WRITE, 20'hFFFFF, 8'hFF);
      host_access(OP_READ, 20'hFFFFF, 8'h00);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_settings();
         steady = ($urandom_range(0, 3) == 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            low_part = ($urandom_range(0, 7) != 0) ? hot_offsets[$urandom_range(0, 15)]
                                                   : 16'($urandom_range(0, 16'hFFFF));
            rand_addr = {4'($urandom_range(0, 15)), low_part};
            pick = $urandom_range(0, 7);
            rand_data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            host_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, rand_addr, rand_data);
         end
      end
      steady = 1'b0;

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
sv/vpma_pkg.sv
sv/vpma_if.sv
sv/vpma_csr.sv
sv/vpma_mem.sv
sv/vpma_issue.sv
sv/vpma_result.sv
sv/vga_planar_memory_access_core.sv
bench/vga_planar_memory_access_checker.sv
bench/vga_planar_memory_access_core_test.sv
